@@ rtl/tcw_pkg.sv @@
// Shared types and constants for the text console cell writer.
// Holds store geometry, character codes, register indexes and the structs
// passed between the control, cell store and top level. No dependencies.
package tcw_pkg;

  // Store geometry
  localparam int LINES    = 128;
  localparam int MAX_COLS = 240;
  localparam int NCELLS   = LINES * MAX_COLS;
  localparam int LINE_W   = $clog2(LINES);
  localparam int ADDR_W   = $clog2(NCELLS);
  // Width for line + row count sums in the view follow logic
  localparam int SUM_W    = ((LINE_W > 8) ? LINE_W : 8) + 1;

  // Character codes
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_FIRST = 8'd32;
  localparam logic [7:0] CH_LAST  = 8'd126;
  localparam logic [6:0] CH_SPACE = 7'd32;

  // Colors
  localparam logic [31:0] WHITE_ARGB = 32'hFFFF_FFFF;
  localparam logic [31:0] BLACK_ARGB = 32'hFF00_0000;

  // Register indexes on the configuration port
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VISIBLE_ROWS = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_FG      = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_BG      = 4'd3;

  typedef struct packed {
    logic [6:0]  ch;
    logic [31:0] fg;
    logic [31:0] bg;
  } cell_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    cell_t             wdata;
  } mem_req_t;

  typedef struct packed {
    logic [7:0]  columns;
    logic [7:0]  visible_rows;
    logic [31:0] text_fg;
    logic [31:0] text_bg;
  } cfg_t;

  typedef struct packed {
    logic [6:0]  cursor_line;
    logic [7:0]  cursor_col;
    logic [6:0]  view_start;
    logic [6:0]  cell_char;
    logic [31:0] cell_fg;
    logic [31:0] cell_bg;
    logic        read_ok;
    logic [31:0] printed_count;
  } result_t;

endpackage

@@ rtl/tcw_cell_store.sv @@
// Single-port cell store: character and colors of every buffer cell.
// Synchronous write; registered read, data appears in the cycle after the request.
// Depends on tcw_pkg.
module tcw_cell_store
  import tcw_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output cell_t    rdata
);

  cell_t mem [NCELLS];

  // Write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
  end

  // Read port; data holds until the next read
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

@@ rtl/tcw_ctrl.sv @@
// Sequencer for the console: cursor, view and count registers, the line ring
// base, and all cell store traffic (reset clear, cell writes, scroll clear,
// reads). Depends on tcw_pkg; drives tcw_cell_store through a request struct.
module tcw_ctrl
  import tcw_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     in_valid,
  output logic     in_stall,
  input  logic     cmd,
  input  logic [7:0] char_code,
  input  logic [7:0] read_line,
  input  logic [7:0] read_col,
  output mem_req_t mem_req,
  input  cell_t    mem_rdata,
  input  logic     out_free,
  output logic     res_push,
  output result_t  res
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_SCROLL,
    S_RESULT
  } state_t;

  state_t state, state_next;

  // Latched item
  logic       item_cmd;
  logic [7:0] item_code;
  logic [7:0] item_rl;
  logic [7:0] item_rc;

  // Cursor and view state; base is the physical line of logical line 0
  logic [LINE_W-1:0] line, line_next;
  logic [7:0]        col, col_next;
  logic [LINE_W-1:0] view, view_next;
  logic [LINE_W-1:0] base, base_next;
  logic [31:0]       printed, printed_next;

  // Sweep pointer for reset and scroll clears
  logic [ADDR_W-1:0] sweep_addr, sweep_addr_next;
  logic [ADDR_W-1:0] sweep_end, sweep_end_next;

  logic [8:0] lim;
  logic [7:0] rows;
  logic       rd_ok;
  logic       nl;
  logic       scroll;
  logic       wr;
  logic [6:0] wr_ch;
  logic [7:0] wr_col;
  logic [8:0] col9;
  logic [8:0] tab9;
  logic [ADDR_W-1:0] clr_addr;

  // Map a logical line onto the ring
  function automatic logic [LINE_W-1:0] phys(input logic [LINE_W-1:0] l,
                                             input logic [LINE_W-1:0] b);
    logic [LINE_W:0] s;
    s = {1'b0, l} + {1'b0, b};
    if (s >= (LINE_W+1)'(LINES)) begin
      s = s - (LINE_W+1)'(LINES);
    end
    return s[LINE_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [LINE_W-1:0] p,
                                                  input logic [7:0] c);
    return ADDR_W'(p) * ADDR_W'(MAX_COLS) + ADDR_W'(c);
  endfunction

  // Effective limits
  always_comb begin
    if (cfg.columns == 8'd0) begin
      lim = 9'd1;
    end else if ({1'b0, cfg.columns} > 9'(MAX_COLS)) begin
      lim = 9'(MAX_COLS);
    end else begin
      lim = {1'b0, cfg.columns};
    end
    rows = (cfg.visible_rows == 8'd0) ? 8'd1 : cfg.visible_rows;
  end

  assign rd_ok = item_cmd && (int'(item_rl) < LINES) && ({1'b0, item_rc} < lim);
  assign in_stall = (state != S_IDLE);

  // Next state, cursor update and store requests
  always_comb begin
    state_next      = state;
    line_next       = line;
    col_next        = col;
    view_next       = view;
    base_next       = base;
    printed_next    = printed;
    sweep_addr_next = sweep_addr;
    sweep_end_next  = sweep_end;
    mem_req         = '0;
    res_push        = 1'b0;
    nl              = 1'b0;
    scroll          = 1'b0;
    wr              = 1'b0;
    wr_ch           = CH_SPACE;
    wr_col          = col;
    col9            = {1'b0, col};
    tab9            = '0;
    clr_addr        = '0;

    case (state)
      S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = sweep_addr;
        mem_req.wdata = '{ch: CH_SPACE, fg: WHITE_ARGB, bg: BLACK_ARGB};
        if (sweep_addr == ADDR_W'(NCELLS - 1)) begin
          state_next = S_IDLE;
        end else begin
          sweep_addr_next = sweep_addr + ADDR_W'(1);
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        if (item_cmd) begin
          if (rd_ok) begin
            mem_req.re   = 1'b1;
            mem_req.addr = cell_addr(phys(LINE_W'(item_rl), base), item_rc);
            state_next   = S_RESULT;
          end else if (out_free) begin
            res_push   = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_RESULT;
          end
        end else begin
          // Decode the character
          case (item_code)
            CH_LF: nl = 1'b1;
            CH_CR: col_next = 8'd0;
            CH_TAB: begin
              tab9     = (col9 + 9'd8) & ~9'd7;
              col_next = tab9[7:0];
              if (tab9 >= lim) begin
                nl = 1'b1;
              end
            end
            CH_BS: begin
              if (col != 8'd0) begin
                col_next = col - 8'd1;
                wr_col   = col - 8'd1;
                if ({1'b0, wr_col} < lim) begin
                  wr = 1'b1;
                end
              end
            end
            default: begin
              if (item_code inside {[CH_FIRST:CH_LAST]}) begin
                if (col9 < lim) begin
                  wr    = 1'b1;
                  wr_ch = item_code[6:0];
                end
                col_next     = col + 8'd1;
                printed_next = printed + 32'd1;
                if (col9 + 9'd1 >= lim) begin
                  nl = 1'b1;
                end
              end
            end
          endcase

          // Cell write at the cursor line, before any scroll
          if (wr) begin
            mem_req.we    = 1'b1;
            mem_req.addr  = cell_addr(phys(line, base), wr_col);
            mem_req.wdata = '{ch: wr_ch, fg: cfg.text_fg, bg: cfg.text_bg};
          end

          // New line: advance or rotate the ring, then follow with the view
          if (nl) begin
            col_next = 8'd0;
            if (line == LINE_W'(LINES - 1)) begin
              scroll    = 1'b1;
              base_next = (base == LINE_W'(LINES - 1)) ? '0 : base + LINE_W'(1);
            end else begin
              line_next = line + LINE_W'(1);
            end
            if (SUM_W'(line_next) >= SUM_W'(view) + SUM_W'(rows)) begin
              view_next = LINE_W'(SUM_W'(line_next) + SUM_W'(1) - SUM_W'(rows));
            end
          end

          if (scroll) begin
            // Old line 0 becomes the new last line; clear it
            clr_addr        = cell_addr(base, 8'd0);
            sweep_addr_next = clr_addr;
            sweep_end_next  = clr_addr + ADDR_W'(MAX_COLS - 1);
            state_next      = S_SCROLL;
          end else if (out_free) begin
            res_push   = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_RESULT;
          end
        end
      end

      S_SCROLL: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = sweep_addr;
        mem_req.wdata = '{ch: CH_SPACE, fg: cfg.text_fg, bg: cfg.text_bg};
        if (sweep_addr == sweep_end) begin
          state_next = S_RESULT;
        end else begin
          sweep_addr_next = sweep_addr + ADDR_W'(1);
        end
      end

      S_RESULT: begin
        if (out_free) begin
          res_push   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // Result fields; outside EXEC the next values equal the current ones
  always_comb begin
    res.cursor_line   = 7'(line_next);
    res.cursor_col    = col_next;
    res.view_start    = 7'(view_next);
    res.printed_count = printed_next;
    res.read_ok       = rd_ok;
    res.cell_char     = rd_ok ? mem_rdata.ch : CH_SPACE;
    res.cell_fg       = rd_ok ? mem_rdata.fg : 32'd0;
    res.cell_bg       = rd_ok ? mem_rdata.bg : 32'd0;
  end

  // Hold state and cursor registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      line       <= '0;
      col        <= '0;
      view       <= '0;
      base       <= '0;
      printed    <= '0;
      sweep_addr <= '0;
    end else begin
      state      <= state_next;
      line       <= line_next;
      col        <= col_next;
      view       <= view_next;
      base       <= base_next;
      printed    <= printed_next;
      sweep_addr <= sweep_addr_next;
    end
  end

  // Capture the item on transfer
  always_ff @(posedge clk) begin
    sweep_end <= sweep_end_next;
    if (state == S_IDLE && in_valid) begin
      item_cmd  <= cmd;
      item_code <= char_code;
      item_rl   <= read_line;
      item_rc   <= read_col;
    end
  end

  // Checks
  a_one_access: assert property (@(posedge clk) disable iff (rst)
    !(mem_req.we && mem_req.re))
    else $error("cell store read and write in one cycle");

  a_push_free: assert property (@(posedge clk) disable iff (rst)
    res_push |-> out_free)
    else $error("result pushed into a full output register");

  a_view_le_line: assert property (@(posedge clk) disable iff (rst)
    view <= line)
    else $error("view start beyond cursor line");

  a_read_then_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && rd_ok) |=> (state == S_RESULT && !mem_req.we))
    else $error("read data disturbed before result");

endmodule

@@ rtl/text_console_cell_writer_core.sv @@
// Top level of the text console cell writer: configuration registers,
// output register, and the sequencer and cell store instances.
// Depends on tcw_pkg, tcw_ctrl and tcw_cell_store.
//
//   channel | handshake                  | payload
//   --------+----------------------------+-----------------------------------
//   input   | in_valid / in_stall        | cmd, char_code, read_line, read_col
//   output  | out_valid / out_stall      | cursor_line .. printed_count
//   config  | cfg_write                  | cfg_index, cfg_data
//
// Put: transfer, then execute with the cell write. Read in range: transfer,
// store read, result; out of range: transfer, execute. A new line from the
// last buffer line adds a clear of the new last line, cell by cell, then the
// result. After reset the store is cleared over LINES*MAX_COLS cells (30720)
// with in_stall high; config writes still land.
// The output register lets the next item transfer while a result waits.
module text_console_cell_writer_core
  import tcw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // Configuration
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  // Input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 cmd,
  input  logic [7:0]           char_code,
  input  logic [7:0]           read_line,
  input  logic [7:0]           read_col,
  // Output channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [6:0]           cursor_line,
  output logic [7:0]           cursor_col,
  output logic [6:0]           view_start,
  output logic [6:0]           cell_char,
  output logic [31:0]          cell_fg,
  output logic [31:0]          cell_bg,
  output logic                 read_ok,
  output logic [31:0]          printed_count
);

  cfg_t     cfg;
  mem_req_t mem_req;
  cell_t    mem_rdata;
  logic     out_free;
  logic     res_push;
  result_t  res;
  result_t  out_reg;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.columns      <= 8'd80;
      cfg.visible_rows <= 8'd29;
      cfg.text_fg      <= WHITE_ARGB;
      cfg.text_bg      <= BLACK_ARGB;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_COLUMNS:      cfg.columns      <= cfg_data[7:0];
        CFG_VISIBLE_ROWS: cfg.visible_rows <= cfg_data[7:0];
        CFG_TEXT_FG:      cfg.text_fg      <= cfg_data;
        CFG_TEXT_BG:      cfg.text_bg      <= cfg_data;
        default: ;
      endcase
    end
  end

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .char_code (char_code),
    .read_line (read_line),
    .read_col  (read_col),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .out_free  (out_free),
    .res_push  (res_push),
    .res       (res)
  );

  tcw_cell_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  // Output register: load on push, drop valid once the transfer completes
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      out_reg <= res;
    end
  end

  assign cursor_line   = out_reg.cursor_line;
  assign cursor_col    = out_reg.cursor_col;
  assign view_start    = out_reg.view_start;
  assign cell_char     = out_reg.cell_char;
  assign cell_fg       = out_reg.cell_fg;
  assign cell_bg       = out_reg.cell_bg;
  assign read_ok       = out_reg.read_ok;
  assign printed_count = out_reg.printed_count;

endmodule

@@ test/text_console_cell_writer_core_tb.sv @@
`timescale 1ns / 1ps
// Testbench for text_console_cell_writer_core: streams put and read transfers
// through a shadow of the cell store, cursor and view, and checks every result.
// Depends on tcw_pkg and the RTL of the core; reads no files.
module text_console_cell_writer_core_tb;
  import tcw_pkg::*;

  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 4'd15;
  localparam int TAB_STOP      = 8;
  localparam int SETTLE_CYCLES = MAX_COLS + 60;
  localparam int LONG_HOLD     = 400;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic       cmd;
    logic [7:0] code;
    logic [7:0] line;
    logic [7:0] col;
  } console_item_t;

  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_EVERY_THIRD} rx_mode_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 cmd = CMD_PUT;
  logic [7:0]           char_code = '0;
  logic [7:0]           read_line = '0;
  logic [7:0]           read_col = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [6:0]           cursor_line;
  logic [7:0]           cursor_col;
  logic [6:0]           view_start;
  logic [6:0]           cell_char;
  logic [31:0]          cell_fg;
  logic [31:0]          cell_bg;
  logic                 read_ok;
  logic [31:0]          printed_count;

  text_console_cell_writer_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .cmd           (cmd),
    .char_code     (char_code),
    .read_line     (read_line),
    .read_col      (read_col),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .cursor_line   (cursor_line),
    .cursor_col    (cursor_col),
    .view_start    (view_start),
    .cell_char     (cell_char),
    .cell_fg       (cell_fg),
    .cell_bg       (cell_bg),
    .read_ok       (read_ok),
    .printed_count (printed_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow console state; lines live in a ring so a scroll moves the top and blanks one line
  logic [6:0]  shadow_char [NCELLS];
  logic [31:0] shadow_fg   [NCELLS];
  logic [31:0] shadow_bg   [NCELLS];
  int unsigned top_line, cur_line, cur_col, view_line, printed;
  logic [7:0]  set_columns, set_rows;
  logic [31:0] set_fg, set_bg;

  console_item_t item_q[$];
  result_t       expect_q[$];
  int unsigned   mismatches = 0;
  int unsigned   results_seen = 0;

  function automatic int unsigned usable_cols();
    if (set_columns == 0) return 1;
    if (set_columns > MAX_COLS) return MAX_COLS;
    return 32'(set_columns);
  endfunction

  function automatic int unsigned shown_rows();
    return (set_rows == 0) ? 32'd1 : 32'(set_rows);
  endfunction

  function automatic int unsigned cell_index(int unsigned line, int unsigned col);
    return ((line + top_line) % LINES) * MAX_COLS + col;
  endfunction

  function automatic void paint(int unsigned idx, logic [6:0] ch);
    shadow_char[idx] = ch;
    shadow_fg[idx]   = set_fg;
    shadow_bg[idx]   = set_bg;
  endfunction

  // Go to column 0 of the next line; scroll at the bottom, then drag the view
  function automatic void feed_line();
    int unsigned k;
    cur_col = 0;
    cur_line++;
    if (cur_line >= LINES) begin
      top_line = (top_line + 1) % LINES;
      cur_line = LINES - 1;
      for (k = 0; k < MAX_COLS; k++) paint(cell_index(LINES - 1, k), CH_SPACE);
    end
    if (cur_line >= view_line + shown_rows()) view_line = cur_line + 1 - shown_rows();
  endfunction

  function automatic void write_code(logic [7:0] code);
    int unsigned lim;
    lim = usable_cols();
    if (code == CH_LF) begin
      feed_line();
    end else if (code == CH_CR) begin
      cur_col = 0;
    end else if (code == CH_TAB) begin
      cur_col = (cur_col + TAB_STOP) & ~(TAB_STOP - 1);
      if (cur_col >= lim) feed_line();
    end else if (code == CH_BS) begin
      if (cur_col > 0) begin
        cur_col--;
        if (cur_col < lim) paint(cell_index(cur_line, cur_col), CH_SPACE);
      end
    end else if (code >= CH_FIRST && code <= CH_LAST) begin
      // A cursor left past a shrunk limit writes nothing, but the character still counts and feeds a new line
      if (cur_col < lim) paint(cell_index(cur_line, cur_col), code[6:0]);
      cur_col++;
      printed++;
      if (cur_col >= lim) feed_line();
    end
  endfunction

  function automatic result_t console_step(console_item_t it);
    result_t     r;
    int unsigned idx;
    r.cell_char = CH_SPACE;
    r.cell_fg   = '0;
    r.cell_bg   = '0;
    r.read_ok   = 1'b0;
    if (it.cmd == CMD_PUT) begin
      write_code(it.code);
    end else if (it.line < LINES && it.col < usable_cols()) begin
      idx = cell_index(it.line, it.col);
      r.cell_char = shadow_char[idx];
      r.cell_fg   = shadow_fg[idx];
      r.cell_bg   = shadow_bg[idx];
      r.read_ok   = 1'b1;
    end
    r.cursor_line   = cur_line[6:0];
    r.cursor_col    = cur_col[7:0];
    r.view_start    = view_line[6:0];
    r.printed_count = printed;
    return r;
  endfunction

  // Stimulus helpers
  function automatic void queue_put(logic [7:0] code);
    console_item_t it;
    it.cmd  = CMD_PUT;
    it.code = code;
    it.line = 8'($urandom_range(0, 255));
    it.col  = 8'($urandom_range(0, 255));
    item_q.push_back(it);
  endfunction

  function automatic void queue_read(logic [7:0] line, logic [7:0] col);
    console_item_t it;
    it.cmd  = CMD_READ;
    it.code = 8'($urandom_range(0, 255));
    it.line = line;
    it.col  = col;
    item_q.push_back(it);
  endfunction

  function automatic void queue_random(int unsigned lf_pct);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      // Mostly reads inside the store, some anywhere in the field range
      if ($urandom_range(0, 9) < 7)
        queue_read(8'($urandom_range(0, LINES - 1)),
                   8'($urandom_range(0, usable_cols() - 1)));
      else
        queue_read(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < lf_pct) queue_put(CH_LF);
      else if (pick < lf_pct + 8) queue_put(CH_TAB);
      else if (pick < lf_pct + 14) queue_put(CH_BS);
      else if (pick < lf_pct + 18) queue_put(CH_CR);
      else if (pick < lf_pct + 24) queue_put(8'($urandom_range(0, 255)));
      else queue_put(8'($urandom_range(CH_FIRST, CH_LAST)));
    end
  endfunction

  // Hold until nothing is offered or pending, then let a line clear finish
  task automatic wait_idle();
    do @(negedge clk);
    while (item_q.size() != 0 || in_valid || expect_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_put(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
  endtask

  task automatic run_phase(logic [7:0] cols, logic [7:0] rows, logic [31:0] fg,
                           logic [31:0] bg, int unsigned count, int unsigned lf_pct,
                           int unsigned tail_chars);
    logic [31:0] junk;
    int unsigned k;
    wait_idle();
    junk = $urandom;
    cfg_put(CFG_COLUMNS, {junk[31:8], cols});
    cfg_put(CFG_VISIBLE_ROWS, {junk[23:0], rows});
    cfg_put(CFG_TEXT_FG, fg);
    cfg_put(CFG_TEXT_BG, bg);
    cfg_put(CFG_UNUSED, junk);
    @(posedge clk);
    cfg_write <= 1'b0;
    set_columns = cols;
    set_rows    = rows;
    set_fg      = fg;
    set_bg      = bg;
    @(negedge clk);
    for (k = 0; k < count; k++) queue_random(lf_pct);
    // Leave the cursor far right so the next phase can shrink the limit under it
    for (k = 0; k < tail_chars; k++) queue_put(8'($urandom_range(CH_FIRST, CH_LAST)));
  endtask

  // Driver: bursts of transfers separated by random gaps
  console_item_t next_item;
  int unsigned   burst_left = 0;
  int unsigned   gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (item_q.size() != 0) begin
        next_item = item_q.pop_front();
        in_valid  <= 1'b1;
        cmd       <= next_item.cmd;
        char_code <= next_item.code;
        read_line <= next_item.line;
        read_col  <= next_item.col;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Predict each accepted input transfer
  console_item_t taken;

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      taken = {cmd, char_code, read_line, read_col};
      expect_q.push_back(console_step(taken));
    end
  end

  // Receiver: stretches of open, random and periodic stall, plus one long hold
  rx_mode_t    rx_mode = RX_OPEN;
  int unsigned stretch_left = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall    <= 1'b0;
      rx_mode      <= RX_OPEN;
      stretch_left <= 0;
      hold_left    <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen > 200 && item_q.size() > 40) begin
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else begin
      if (stretch_left == 0) begin
        rx_mode      <= rx_mode_t'($urandom_range(0, 2));
        stretch_left <= $urandom_range(8, 48);
      end else begin
        stretch_left <= stretch_left - 1;
      end
      case (rx_mode)
        RX_OPEN:   out_stall <= 1'b0;
        RX_RANDOM: out_stall <= ($urandom_range(0, 1) == 1);
        default:   out_stall <= (stretch_left % 3 == 0);
      endcase
    end
  end

  // Compare each result transfer with the oldest prediction
  result_t seen_res, want_res;

  function automatic void note_mismatch(string what, result_t want, result_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t %s: expected line %0d col %0d view %0d char %0d fg %h bg %h ok %0d cnt %0d",
               $time, what, want.cursor_line, want.cursor_col, want.view_start,
               want.cell_char, want.cell_fg, want.cell_bg, want.read_ok, want.printed_count);
      $display("%0t %s: actual   line %0d col %0d view %0d char %0d fg %h bg %h ok %0d cnt %0d",
               $time, what, got.cursor_line, got.cursor_col, got.view_start,
               got.cell_char, got.cell_fg, got.cell_bg, got.read_ok, got.printed_count);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen_res.cursor_line   = cursor_line;
      seen_res.cursor_col    = cursor_col;
      seen_res.view_start    = view_start;
      seen_res.cell_char     = cell_char;
      seen_res.cell_fg       = cell_fg;
      seen_res.cell_bg       = cell_bg;
      seen_res.read_ok       = read_ok;
      seen_res.printed_count = printed_count;
      results_seen <= results_seen + 1;
      if (expect_q.size() == 0) begin
        note_mismatch("unexpected result", '0, seen_res);
      end else begin
        want_res = expect_q.pop_front();
        if (seen_res.cursor_line !== want_res.cursor_line ||
            seen_res.cursor_col !== want_res.cursor_col ||
            seen_res.view_start !== want_res.view_start ||
            seen_res.cell_char !== want_res.cell_char ||
            seen_res.cell_fg !== want_res.cell_fg ||
            seen_res.cell_bg !== want_res.cell_bg ||
            seen_res.read_ok !== want_res.read_ok ||
            seen_res.printed_count !== want_res.printed_count)
          note_mismatch("result mismatch", want_res, seen_res);
      end
    end
  end

  // Main sequence
  int unsigned k;

  initial begin
    for (k = 0; k < NCELLS; k++) begin
      shadow_char[k] = CH_SPACE;
      shadow_fg[k]   = WHITE_ARGB;
      shadow_bg[k]   = BLACK_ARGB;
    end
    top_line    = 0;
    cur_line    = 0;
    cur_col     = 0;
    view_line   = 0;
    printed     = 0;
    set_columns = 8'd80;
    set_rows    = 8'd29;
    set_fg      = WHITE_ARGB;
    set_bg      = BLACK_ARGB;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: printable extremes, every control, ignored codes, read edges
    queue_read(8'd0, 8'd0);
    queue_put(CH_FIRST);
    queue_put(CH_LAST);
    queue_put(CH_TAB);
    queue_put(CH_BS);
    queue_put(CH_CR);
    queue_put(CH_BS);
    queue_put(8'd0);
    queue_put(CH_FIRST - 8'd1);
    queue_put(CH_LAST + 8'd1);
    queue_put(8'd128);
    queue_put(8'd255);
    queue_put(CH_LF);
    queue_read(8'd0, 8'd0);
    queue_read(8'd0, 8'd1);
    queue_read(8'd0, 8'd7);
    queue_read(8'(LINES - 1), 8'd79);
    queue_read(8'(LINES), 8'd0);
    queue_read(8'd0, 8'd80);
    queue_read(8'd255, 8'd255);
    queue_put("A");

    // Random phases over several register settings, extremes included
    run_phase(8'd40, 8'd15, $urandom, $urandom, 150, 25, 0);
    run_phase(8'd240, 8'd255, 32'h0000_0000, 32'hFFFF_FFFF, 140, 20, 60);
    run_phase(8'd47, 8'd128, $urandom, $urandom, 150, 15, 0);
    run_phase(8'd0, 8'd0, WHITE_ARGB, 32'h0000_0000, 120, 10, 0);
    run_phase(8'd255, 8'd1, $urandom, $urandom, 150, 30, 0);
    run_phase(8'($urandom_range(40, 240)), 8'($urandom_range(15, 255)), $urandom, $urandom,
              150, 20, 0);

    wait_idle();
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Watchdog: reset clear plus every item at its slowest, several times over
  initial begin
    #30_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/tcw_pkg.sv
rtl/tcw_cell_store.sv
rtl/tcw_ctrl.sv
rtl/text_console_cell_writer_core.sv
test/text_console_cell_writer_core_tb.sv
